@@ hw/rtl/fcsp_pkg.sv @@
// ----------------------------------------------------------------------------
// Framed CSV status parser package
// Shared widths, register indexes and the result record layout.
// ----------------------------------------------------------------------------
package fcsp_pkg;

    // Default number of bytes kept from the body of one frame.
    localparam int KEEP_BYTES_DEF = 31;

    // Number of comma-separated fields in a valid frame.
    localparam int FIELD_COUNT = 5;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_COUNT  = 2'd2;

    // Register reset values.
    localparam logic [7:0] START_MARKER_RST = 8'd60;
    localparam logic [7:0] END_MARKER_RST   = 8'd62;
    localparam logic [6:0] FLOOR_COUNT_RST  = 7'd18;

    // Floor limit ceiling, so that floor outputs fit in six bits.
    localparam logic [6:0] FLOOR_CAP = 7'd64;

    // Character codes.
    localparam logic [7:0] CHR_NUL   = 8'h00;
    localparam logic [7:0] CHR_COMMA = 8'h2C;
    localparam logic [7:0] CHR_MINUS = 8'h2D;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;

    // Service field codes on the link and their encoded results.
    localparam logic [7:0] SVC_CODE_FAULT    = 8'd1;
    localparam logic [7:0] SVC_CODE_REVISION = 8'd2;
    localparam logic [7:0] SVC_CODE_MISSING  = 8'd3;
    localparam logic [7:0] SVC_CODE_NORMAL   = 8'd5;

    localparam logic [1:0] SVC_NORMAL   = 2'd0;
    localparam logic [1:0] SVC_FAULT    = 2'd1;
    localparam logic [1:0] SVC_REVISION = 2'd2;
    localparam logic [1:0] SVC_MISSING  = 2'd3;

    // Stream data widths.
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    // Result record, frame_ok in the lowest bit of the packed vector.
    typedef struct packed {
        logic [5:0] pad;
        logic [1:0] service;
        logic [1:0] direction;
        logic       busy_res;
        logic [5:0] floor_target;
        logic [5:0] floor_now;
        logic       frame_ok;
    } t_result;

endpackage

@@ hw/rtl/framed_csv_status_parser_unit.sv @@
// ----------------------------------------------------------------------------
// Framed CSV status parser
// Parses framed, comma-separated lift status records from a byte stream.
// ----------------------------------------------------------------------------
// Throughput: one byte transaction per clock cycle while the skid register is
// empty. The end-marker transaction registers the frame's result into the
// output buffer; all byte work is one combinational pass. The two-entry
// buffer (head and skid register) keeps bytes flowing while a result waits.
// Reset (i_rst_n low, synchronous) clears the frame state and the output
// buffer and loads the marker and floor-count registers with their defaults.
module framed_csv_status_parser_unit
    import fcsp_pkg::*;
#(
    parameter int KEEP_BYTES = KEEP_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write channel.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Byte input stream.
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,   // [7:0] data_byte
    // Result stream.
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [0] frame_ok, [6:1] floor_now, [12:7] floor_target, [13] busy_res,
    // [15:14] direction, [17:16] service, [23:18] zero
    output logic [M_TDATA_W-1:0]  o_m_tdata
);

    localparam int KEEP_W = $clog2(KEEP_BYTES + 1);
    localparam int FLD_STORED = FIELD_COUNT - 1;

    // ------------------------------------------------------------------------
    // Configuration registers. Writes are always accepted; indexes beyond the
    // register list are ignored.
    // ------------------------------------------------------------------------
    logic [7:0] r_start_marker;
    logic [7:0] r_end_marker;
    logic [6:0] r_floor_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= START_MARKER_RST;
            r_end_marker   <= END_MARKER_RST;
            r_floor_count  <= FLOOR_COUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_START_MARKER: r_start_marker <= i_cfg_data[7:0];
                REG_END_MARKER:   r_end_marker   <= i_cfg_data[7:0];
                REG_FLOOR_COUNT:  r_floor_count  <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Frame and field state.
    // ------------------------------------------------------------------------
    logic              r_in_frame,  n_in_frame;
    logic [KEEP_W-1:0] r_kept,      n_kept;
    logic              r_stopped,   n_stopped;
    logic [2:0]        r_commas,    n_commas;
    logic              r_has_char,  n_has_char;
    logic              r_neg,       n_neg;
    logic [7:0]        r_acc,       n_acc;
    logic              r_bad,       n_bad;

    // The first four fields are held here as each comma closes them; the last
    // field is still in the accumulator when the end marker arrives.
    logic [7:0]        r_fld [FLD_STORED];
    logic              fld_we;

    // ------------------------------------------------------------------------
    // Output buffer: a head register and a skid register behind it.
    // ------------------------------------------------------------------------
    t_result r_out, r_skid;
    logic    r_out_valid, r_skid_valid;

    logic    s_acc;
    logic    pop;
    logic    push;
    t_result res;

    assign o_s_tready = !r_skid_valid;
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign pop        = r_out_valid && i_m_tready;

    // ------------------------------------------------------------------------
    // Byte classification and per-byte field arithmetic.
    // ------------------------------------------------------------------------
    logic [7:0]  byte_in;
    logic        is_end;
    logic        is_digit;
    logic [3:0]  digit;
    logic [11:0] acc_x10;
    logic        close_bad;
    logic        cur_bad;
    logic [7:0]  lim;
    logic        fields_ok;
    logic [1:0]  svc;
    logic        svc_ok;
    logic        frame_ok;

    assign byte_in  = i_s_tdata[7:0];
    assign is_end   = r_in_frame && (byte_in == r_end_marker);
    assign is_digit = (byte_in >= CHR_ZERO) && (byte_in <= CHR_NINE);
    assign digit    = 4'(byte_in - CHR_ZERO);
    // Ten times the magnitude plus the new digit; saturated at 255 below.
    assign acc_x10  = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + {8'h00, digit};

    // Closing the current field fails the frame if it is empty, or if it is
    // a minus sign followed by a nonzero magnitude.
    assign close_bad = !r_has_char || (r_neg && (r_acc != 8'd0));
    assign cur_bad   = r_bad || close_bad;

    // Floor counts above the cap behave as the cap.
    assign lim = {1'b0, (r_floor_count > FLOOR_CAP) ? FLOOR_CAP : r_floor_count};

    assign fields_ok = (r_fld[0] < lim) && (r_fld[1] < lim)
                    && (r_fld[2] <= 8'd1) && (r_fld[3] <= 8'd2);

    always_comb begin
        svc    = SVC_NORMAL;
        svc_ok = 1'b1;
        unique case (r_acc)
            SVC_CODE_FAULT:    svc = SVC_FAULT;
            SVC_CODE_REVISION: svc = SVC_REVISION;
            SVC_CODE_MISSING:  svc = SVC_MISSING;
            SVC_CODE_NORMAL:   svc = SVC_NORMAL;
            default:           svc_ok = 1'b0;
        endcase
    end

    assign frame_ok = (r_commas == 3'(FIELD_COUNT - 1)) && !cur_bad && fields_ok && svc_ok;

    always_comb begin
        res = '0;
        if (frame_ok) begin
            res.frame_ok     = 1'b1;
            res.floor_now    = r_fld[0][5:0];
            res.floor_target = r_fld[1][5:0];
            res.busy_res     = r_fld[2][0];
            res.direction    = r_fld[3][1:0];
            res.service      = svc;
        end
    end

    assign push = s_acc && is_end;

    // ------------------------------------------------------------------------
    // Next-state logic for one byte transaction.
    // ------------------------------------------------------------------------
    always_comb begin
        n_in_frame = r_in_frame;
        n_kept     = r_kept;
        n_stopped  = r_stopped;
        n_commas   = r_commas;
        n_has_char = r_has_char;
        n_neg      = r_neg;
        n_acc      = r_acc;
        n_bad      = r_bad;
        fld_we     = 1'b0;

        if (s_acc) begin
            if (!r_in_frame) begin
                // Outside a frame only the start marker matters.
                if (byte_in == r_start_marker) begin
                    n_in_frame = 1'b1;
                    n_kept     = '0;
                    n_stopped  = 1'b0;
                    n_commas   = '0;
                    n_has_char = 1'b0;
                    n_neg      = 1'b0;
                    n_acc      = '0;
                    n_bad      = 1'b0;
                end
            end else if (is_end) begin
                n_in_frame = 1'b0;
            end else if (r_kept < KEEP_W'(KEEP_BYTES)) begin
                n_kept = r_kept + KEEP_W'(1);
                if (!r_stopped) begin
                    if (byte_in == CHR_NUL) begin
                        // A zero byte ends the parsed content of the frame.
                        n_stopped = 1'b1;
                    end else if (byte_in == CHR_COMMA) begin
                        n_bad      = cur_bad;
                        fld_we     = (r_commas < 3'(FLD_STORED));
                        n_commas   = (r_commas == 3'd7) ? r_commas : r_commas + 3'd1;
                        n_has_char = 1'b0;
                        n_neg      = 1'b0;
                        n_acc      = '0;
                    end else if (byte_in == CHR_MINUS) begin
                        // A minus is only allowed as the first character.
                        if (r_has_char) begin
                            n_bad = 1'b1;
                        end
                        n_has_char = 1'b1;
                        n_neg      = 1'b1;
                    end else if (is_digit) begin
                        n_acc      = (acc_x10 > 12'd255) ? 8'd255 : acc_x10[7:0];
                        n_has_char = 1'b1;
                    end else begin
                        n_bad = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_kept     <= '0;
            r_stopped  <= 1'b0;
            r_commas   <= '0;
            r_has_char <= 1'b0;
            r_neg      <= 1'b0;
            r_acc      <= '0;
            r_bad      <= 1'b0;
        end else begin
            r_in_frame <= n_in_frame;
            r_kept     <= n_kept;
            r_stopped  <= n_stopped;
            r_commas   <= n_commas;
            r_has_char <= n_has_char;
            r_neg      <= n_neg;
            r_acc      <= n_acc;
            r_bad      <= n_bad;
        end
    end

    // Field store: written only after a frame has started, so it needs no reset.
    always_ff @(posedge i_clk) begin
        if (fld_we) begin
            r_fld[r_commas[1:0]] <= r_acc;
        end
    end

    // ------------------------------------------------------------------------
    // Output buffer control. A result enters the head register when it is
    // free or draining and the skid is empty, else it waits in the skid.
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= push;
            end else begin
                r_out_valid  <= push;
            end
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
                if (push) begin
                    r_skid <= res;
                end
            end else if (push) begin
                r_out <= res;
            end
        end else if (push) begin
            r_skid <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

endmodule

@@ hw/rtl/fcsp_checker.sv @@
// ----------------------------------------------------------------------------
// Framed CSV status parser checker
// Port-level properties of the parser, attached to the top level by bind.
// ----------------------------------------------------------------------------
module fcsp_checker
    import fcsp_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_tvalid,
    input logic                 o_s_tready,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [M_TDATA_W-1:0] o_m_tdata
);

    // A stalled result keeps its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // A failed frame reports all fields as zero.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[0] |-> o_m_tdata[M_TDATA_W-1:1] == '0)
        else $error("failed frame carries nonzero fields");

    // A passed frame never reports an out-of-range direction.
    a_dir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[0] |-> o_m_tdata[15:14] != 2'd3)
        else $error("direction out of range on a passed frame");

    // A result only appears after a byte transaction.
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(i_s_tvalid && o_s_tready))
        else $error("result without a preceding byte transaction");

endmodule

bind framed_csv_status_parser_unit fcsp_checker u_fcsp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
